### sv/pgma_pkg.sv
// Shared types, CORDIC arctangent table and constants of the 2x2 gradient block.
package pgma_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 13;   // 26-bit radicand, two bits per step
  localparam int LVL_STEPS    = 9;    // 18-bit radicand, two bits per step

  localparam longint unsigned ANG_ONE = 64'd1 << 40;

  // Front to back: one classified pixel.
  typedef struct packed {
    logic signed [9:0] dx_half;
    logic signed [9:0] dy_half;
    logic              grad;
    logic              tail;
  } job_t;

  // One result beat.
  typedef struct packed {
    logic signed [9:0]  dx_half;
    logic signed [9:0]  dy_half;
    logic [12:0]        magnitude_q4;
    logic [7:0]         magnitude_level;
    logic signed [14:0] angle_q12;
    logic               row_end;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_EMIT_GRAD,
    BK_EMIT_TAIL
  } back_state_t;

  // 2^40 / 2^(i*m), or zero once the power passes 2^40.
  function automatic longint unsigned pw_shift(input int i, input int m);
    longint unsigned r;
    r = ((i * m) <= 40) ? (ANG_ONE >> (i * m)) : 64'd0;
    return r;
  endfunction

  // atan(2^-i) in Q40 from the truncated alternating power series.
  function automatic longint atan_pow2(input int i);
    longint unsigned acc;
    acc = 64'd0;
    acc = acc + pw_shift(i, 1) / 64'd1;   acc = acc - pw_shift(i, 3) / 64'd3;
    acc = acc + pw_shift(i, 5) / 64'd5;   acc = acc - pw_shift(i, 7) / 64'd7;
    acc = acc + pw_shift(i, 9) / 64'd9;   acc = acc - pw_shift(i, 11) / 64'd11;
    acc = acc + pw_shift(i, 13) / 64'd13; acc = acc - pw_shift(i, 15) / 64'd15;
    acc = acc + pw_shift(i, 17) / 64'd17; acc = acc - pw_shift(i, 19) / 64'd19;
    acc = acc + pw_shift(i, 21) / 64'd21; acc = acc - pw_shift(i, 23) / 64'd23;
    acc = acc + pw_shift(i, 25) / 64'd25; acc = acc - pw_shift(i, 27) / 64'd27;
    acc = acc + pw_shift(i, 29) / 64'd29; acc = acc - pw_shift(i, 31) / 64'd31;
    acc = acc + pw_shift(i, 33) / 64'd33; acc = acc - pw_shift(i, 35) / 64'd35;
    acc = acc + pw_shift(i, 37) / 64'd37; acc = acc - pw_shift(i, 39) / 64'd39;
    return longint'(acc);
  endfunction

  // atan(1/5) and atan(1/239) in Q40 for Machin's formula.
  localparam longint ATAN_5 =
      longint'((ANG_ONE / 64'd5) / 64'd1) - longint'((ANG_ONE / 64'd125) / 64'd3)
    + longint'((ANG_ONE / 64'd3125) / 64'd5) - longint'((ANG_ONE / 64'd78125) / 64'd7)
    + longint'((ANG_ONE / 64'd1953125) / 64'd9)
    - longint'((ANG_ONE / 64'd48828125) / 64'd11)
    + longint'((ANG_ONE / 64'd1220703125) / 64'd13)
    - longint'((ANG_ONE / 64'd30517578125) / 64'd15)
    + longint'((ANG_ONE / 64'd762939453125) / 64'd17);
  localparam longint ATAN_239 =
      longint'((ANG_ONE / 64'd239) / 64'd1)
    - longint'((ANG_ONE / 64'd13651919) / 64'd3)
    + longint'((ANG_ONE / 64'd779811265199) / 64'd5);
  localparam longint ATAN_0  = 4 * ATAN_5 - ATAN_239;
  localparam longint PI_Q40  = 4 * ATAN_0;
  localparam longint PI_Q12  = (PI_Q40 + (64'sd1 <<< 27)) >>> 28;

  localparam longint ATAN_TAB [CORDIC_STEPS] = '{
    ATAN_0,        atan_pow2(1),  atan_pow2(2),  atan_pow2(3),  atan_pow2(4),
    atan_pow2(5),  atan_pow2(6),  atan_pow2(7),  atan_pow2(8),  atan_pow2(9),
    atan_pow2(10), atan_pow2(11), atan_pow2(12), atan_pow2(13), atan_pow2(14),
    atan_pow2(15), atan_pow2(16), atan_pow2(17), atan_pow2(18), atan_pow2(19),
    atan_pow2(20), atan_pow2(21), atan_pow2(22), atan_pow2(23), atan_pow2(24),
    atan_pow2(25), atan_pow2(26), atan_pow2(27), atan_pow2(28), atan_pow2(29)
  };

endpackage

### sv/pixel_gradient_2x2_mag_angle_top.sv
// Top level of the 2x2 gradient magnitude and angle block.
//
//   Channel  | Handshake                 | Beat contents
//   ---------+---------------------------+-------------------------------------------
//   config   | cfg_we                    | cfg_wdata: image_width (13 bits)
//   pixels   | push in, full out         | pixel (8 bits), frame_start
//   results  | pop in, empty out         | dx_half, dy_half, magnitude_q4,
//            |                           | magnitude_level, angle_q12, row_end
//
// The front part takes one pixel per clock while the job queue has room; a pixel's
// line store read is registered alongside it, where its window is formed and queued.
// The back part takes one pixel with a gradient result at a time (load, 30 CORDIC
// iterations that also carry both square roots, emit), then its row-end beat if any,
// so sustained throughput is set by the iterative CORDIC unit.
// Synchronous rst clears all control state and sets image_width to 640; the line
// store is not cleared. full rises once the job queue is full and the front holds
// a beat; a full result queue stalls the back part directly, and the front once the job queue fills.
module pixel_gradient_2x2_mag_angle_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [12:0]        cfg_wdata,
  input  logic [7:0]         pixel,
  input  logic               frame_start,
  input  logic               push,
  output logic               full,
  output logic signed [9:0]  dx_half,
  output logic signed [9:0]  dy_half,
  output logic [12:0]        magnitude_q4,
  output logic [7:0]         magnitude_level,
  output logic signed [14:0] angle_q12,
  output logic               row_end,
  output logic               empty,
  input  logic               pop
);

  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  logic [12:0]    image_width;

  logic           job_push;
  pgma_pkg::job_t job_in;
  logic           job_full;
  logic           job_pop;
  pgma_pkg::job_t job_out;
  logic           job_empty;

  logic           res_push;
  pgma_pkg::res_t res_in;
  logic           res_full;
  pgma_pkg::res_t res_out;

  // The user must write the width register only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd640;
    end else if (cfg_we) begin
      image_width <= cfg_wdata;
    end
  end

  pgma_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .image_width (image_width),
    .pixel       (pixel),
    .frame_start (frame_start),
    .push        (push),
    .full        (full),
    .job_push    (job_push),
    .job         (job_in),
    .job_full    (job_full)
  );

  // Decouples the front, one pixel per clock while it has room, from the iterative back part.
  pgma_fifo #(
    .WIDTH ($bits(pgma_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  pgma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // Holds a gradient beat and its row-end beat so the back part keeps going.
  pgma_fifo #(
    .WIDTH ($bits(pgma_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign dx_half         = res_out.dx_half;
  assign dy_half         = res_out.dy_half;
  assign magnitude_q4    = res_out.magnitude_q4;
  assign magnitude_level = res_out.magnitude_level;
  assign angle_q12       = res_out.angle_q12;
  assign row_end         = res_out.row_end;

endmodule

### sv/pgma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/pgma_fifo.sv
// Small register queue with show-ahead read.
module pgma_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr & ~do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd & ~do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### sv/pgma_front.sv
// Front part: column tracking, line store, window assembly and gradient sums.
module pgma_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [12:0]    image_width,
  input  logic [7:0]     pixel,
  input  logic           frame_start,
  input  logic           push,
  output logic           full,
  output logic           job_push,
  output pgma_pkg::job_t job,
  input  logic           job_full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = ((CW + 1) > 13) ? (CW + 1) : 13;

  logic [CW-1:0] column_count;
  logic          first_row;
  logic [7:0]    left_cur;
  logic [7:0]    left_above;

  logic          s1_valid;
  logic [7:0]    s1_px;
  logic [CW-1:0] s1_col;
  logic          s1_first;
  logic          s1_last;
  logic          s1_fwd;
  logic [7:0]    fwd_px;

  logic          accept;
  logic          s1_fire;
  logic [LW-1:0] width_ext;
  logic [LW-1:0] width_use;
  logic [CW-1:0] col_eff;
  logic [LW-1:0] col_inc;
  logic          first_eff;
  logic          last;
  logic [7:0]    ram_rdata;
  logic [7:0]    above;
  logic signed [9:0] pa, pb, pc, pd;

  assign accept  = push & ~full;
  assign s1_fire = s1_valid & ~job_full;
  assign full    = s1_valid & job_full;

  assign width_ext = LW'(image_width);
  always_comb begin
    if (width_ext < LW'(2)) begin
      width_use = LW'(2);
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      width_use = LW'(MAX_WIDTH);
    end else begin
      width_use = width_ext;
    end
  end

  assign col_eff   = frame_start ? '0 : column_count;
  assign first_eff = frame_start | first_row;
  assign col_inc   = LW'(col_eff) + LW'(1);
  assign last      = (col_inc >= width_use);

  // Same-address read while the previous pixel is written takes the new pixel.
  assign above = s1_fwd ? fwd_px : ram_rdata;

  assign pa = signed'({2'b00, left_above});
  assign pb = signed'({2'b00, above});
  assign pc = signed'({2'b00, left_cur});
  assign pd = signed'({2'b00, s1_px});

  always_comb begin
    job.dx_half = pd + pc - pb - pa;
    job.dy_half = pd + pb - pc - pa;
    job.grad    = ~s1_first & (s1_col != '0);
    job.tail    = ~s1_first & s1_last;
  end

  assign job_push = s1_fire & (job.grad | job.tail);

  pgma_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (s1_px),
    .re    (accept),
    .raddr (col_eff),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
      left_cur     <= '0;
      left_above   <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept | (s1_valid & ~s1_fire);
      if (accept) begin
        column_count <= last ? '0 : col_inc[CW-1:0];
        first_row    <= first_eff & ~last;
      end
      if (s1_fire) begin
        left_above <= above;
        left_cur   <= s1_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= pixel;
      s1_col   <= col_eff;
      s1_first <= first_eff;
      s1_last  <= last;
      s1_fwd   <= s1_fire & (col_eff == s1_col);
      fwd_px   <= s1_px;
    end
  end

endmodule

### sv/pgma_back.sv
// Back part: iterative square roots and vectoring CORDIC for one pixel at a time.
module pgma_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_empty,
  input  pgma_pkg::job_t job,
  output logic           job_pop,
  output logic           res_push,
  output pgma_pkg::res_t res,
  input  logic           res_full
);

  pgma_pkg::back_state_t state, state_next;

  logic [4:0]         cnt;
  logic               tail;
  logic signed [9:0]  dxh;
  logic signed [9:0]  dyh;
  logic signed [36:0] x;
  logic signed [36:0] y;
  logic signed [44:0] z;
  logic [25:0]        sq_rad;
  logic [15:0]        sq_rem;
  logic [12:0]        sq_root;
  logic [17:0]        lv_rad;
  logic [10:0]        lv_rem;
  logic [8:0]         lv_root;

  logic signed [19:0] dx2, dy2;
  logic [19:0]        sum_sq;
  logic signed [36:0] jx, jy;
  logic signed [36:0] x_sh, y_sh;
  logic signed [44:0] atan_z;
  logic [17:0]        sq_rem2;
  logic [14:0]        sq_trial;
  logic [12:0]        lv_rem2;
  logic [10:0]        lv_trial;
  logic [12:0]        mag_q4;
  logic [7:0]         mag_lvl;
  logic signed [44:0] z_round;
  logic signed [14:0] ang;
  logic               take;

  assign take = (state == pgma_pkg::BK_IDLE) & ~job_empty;

  // Load-time arithmetic.
  assign dx2    = job.dx_half * job.dx_half;
  assign dy2    = job.dy_half * job.dy_half;
  assign sum_sq = 20'(dx2) + 20'(dy2);
  assign jx     = 37'(job.dx_half) <<< 24;
  assign jy     = 37'(job.dy_half) <<< 24;

  // One iteration of each unit.
  assign x_sh     = x >>> cnt;
  assign y_sh     = y >>> cnt;
  assign atan_z   = 45'(pgma_pkg::ATAN_TAB[cnt]);
  assign sq_rem2  = {sq_rem, sq_rad[25:24]};
  assign sq_trial = {sq_root, 2'b01};
  assign lv_rem2  = {lv_rem, lv_rad[17:16]};
  assign lv_trial = {lv_root, 2'b01};

  // Result shaping.
  assign mag_q4  = (sq_rem > 16'(sq_root)) ? sq_root + 13'd1 : sq_root;
  assign mag_lvl = (lv_root > 9'd255) ? 8'd255 : lv_root[7:0];
  assign z_round = z + (45'sd1 <<< 27);
  always_comb begin
    if (dxh == '0) begin
      ang = (dyh < 0) ? '0 : 15'(pgma_pkg::PI_Q12);
    end else begin
      ang = z_round[42:28];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pgma_pkg::BK_IDLE: begin
        if (!job_empty) begin
          state_next = job.grad ? pgma_pkg::BK_RUN : pgma_pkg::BK_EMIT_TAIL;
        end
      end
      pgma_pkg::BK_RUN: begin
        if (cnt == 5'(pgma_pkg::CORDIC_STEPS - 1)) begin
          state_next = pgma_pkg::BK_EMIT_GRAD;
        end
      end
      pgma_pkg::BK_EMIT_GRAD: begin
        if (!res_full) begin
          state_next = tail ? pgma_pkg::BK_EMIT_TAIL : pgma_pkg::BK_IDLE;
        end
      end
      pgma_pkg::BK_EMIT_TAIL: begin
        if (!res_full) begin
          state_next = pgma_pkg::BK_IDLE;
        end
      end
      default: state_next = pgma_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = 1'b0;
    res_push = 1'b0;
    res      = '0;
    case (state)
      pgma_pkg::BK_IDLE: begin
        job_pop = ~job_empty;
      end
      pgma_pkg::BK_EMIT_GRAD: begin
        res_push            = ~res_full;
        res.dx_half         = dxh;
        res.dy_half         = dyh;
        res.magnitude_q4    = mag_q4;
        res.magnitude_level = mag_lvl;
        res.angle_q12       = ang;
      end
      pgma_pkg::BK_EMIT_TAIL: begin
        res_push    = ~res_full;
        res.row_end = 1'b1;
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgma_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cnt     <= '0;
      tail    <= job.tail;
      dxh     <= job.dx_half;
      dyh     <= job.dy_half;
      sq_rad  <= {sum_sq, 6'b000000};
      sq_rem  <= '0;
      sq_root <= '0;
      lv_rad  <= sum_sq[19:2];
      lv_rem  <= '0;
      lv_root <= '0;
      // atan2(dx, -dy): fold the left half plane onto the right.
      if (job.dy_half > 0) begin
        x <= jy;
        y <= -jx;
        z <= (job.dx_half > 0) ? 45'(pgma_pkg::PI_Q40) : -45'(pgma_pkg::PI_Q40);
      end else begin
        x <= -jy;
        y <= jx;
        z <= '0;
      end
    end else if (state == pgma_pkg::BK_RUN) begin
      cnt <= cnt + 5'd1;
      if (y > 0) begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_z;
      end else begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_z;
      end
      if (cnt < 5'(pgma_pkg::SQRT_STEPS)) begin
        sq_rad <= {sq_rad[23:0], 2'b00};
        if (sq_rem2 >= 18'(sq_trial)) begin
          sq_rem  <= 16'(sq_rem2 - 18'(sq_trial));
          sq_root <= {sq_root[11:0], 1'b1};
        end else begin
          sq_rem  <= sq_rem2[15:0];
          sq_root <= {sq_root[11:0], 1'b0};
        end
      end
      if (cnt < 5'(pgma_pkg::LVL_STEPS)) begin
        lv_rad <= {lv_rad[15:0], 2'b00};
        if (lv_rem2 >= 13'(lv_trial)) begin
          lv_rem  <= 11'(lv_rem2 - 13'(lv_trial));
          lv_root <= {lv_root[7:0], 1'b1};
        end else begin
          lv_rem  <= lv_rem2[10:0];
          lv_root <= {lv_root[7:0], 1'b0};
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the 2x2 gradient magnitude and angle block.
module testbench;

  typedef struct {
    logic [7:0] px;
    logic       fs;
  } pix_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [12:0]        cfg_wdata = '0;
  logic [7:0]         pixel = '0;
  logic               frame_start = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [9:0]  dx_half;
  logic signed [9:0]  dy_half;
  logic [12:0]        magnitude_q4;
  logic [7:0]         magnitude_level;
  logic signed [14:0] angle_q12;
  logic               row_end;
  logic               empty;
  logic               pop = 1'b0;

  pixel_gradient_2x2_mag_angle_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pixel(pixel), .frame_start(frame_start), .push(push), .full(full),
    .dx_half(dx_half), .dy_half(dy_half), .magnitude_q4(magnitude_q4),
    .magnitude_level(magnitude_level), .angle_q12(angle_q12), .row_end(row_end),
    .empty(empty), .pop(pop)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Pixels waiting to be offered, and gradient results waiting to come out.
  pix_beat_t      pending_pixels[$];
  pgma_pkg::res_t expected_grads[$];

  // Idle percentages of both sides; the stimulus process switches them.
  int unsigned sender_gap_pct = 22;
  int unsigned receiver_gap_pct = 65;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned grads_checked = 0;
  int unsigned tail_beats = 0;

  // Window tracker state, mirroring what the block keeps between pixels.
  logic [7:0]  row_above[4096];
  logic [7:0]  prev_px;
  logic [7:0]  prev_above;
  int unsigned col_pos;
  bit          in_first_row;
  logic [12:0] width_reg;

  // Arctangent table in Q40 and pi in Q40 and Q12.
  longint atan_q40[30];
  longint pi_q40_val;
  longint pi_q12_val;

  // atan(1/n) in Q40 from the alternating series.
  function automatic longint atan_of_recip(longint unsigned n);
    longint unsigned one, nn, pw, k;
    longint sum, term;
    one = 64'd1 << 40;
    nn = n * n;
    pw = n;
    sum = 0;
    for (k = 0; pw <= one; k++) begin
      term = longint'(one / pw / (2 * k + 1));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      if (pw > one / nn) break;
      pw = pw * nn;
    end
    return sum;
  endfunction

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned r, b;
    r = 0;
    b = 32'd1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC for atan2(yy, xx) in Q3.12, yy nonzero.
  function automatic int cordic_atan2(int yy, int xx);
    longint x, y, z, nx, ny;
    x = longint'(xx) <<< 24;
    y = longint'(yy) <<< 24;
    z = 0;
    if (xx < 0) begin
      z = (yy > 0) ? pi_q40_val : -pi_q40_val;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 30; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + atan_q40[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - atan_q40[i];
      end
      x = nx;
      y = ny;
    end
    return int'((z + (64'sd1 <<< 27)) >>> 28);
  endfunction

  initial begin
    atan_q40[0] = 4 * atan_of_recip(5) - atan_of_recip(239);
    for (int i = 1; i < 30; i++) atan_q40[i] = atan_of_recip(64'd1 << i);
    pi_q40_val = 4 * atan_q40[0];
    pi_q12_val = (pi_q40_val + (64'sd1 <<< 27)) >>> 28;
  end

  // Advance the window tracker by one accepted pixel and queue what it produces.
  function automatic void track_pixel(logic [7:0] px, logic fs);
    int unsigned w;
    logic [7:0] above;
    bit at_last;
    int a, b, c, d, dxh, dyh;
    int unsigned s, big, r, lvl;
    int ang;
    pgma_pkg::res_t g;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > 4096) w = 4096;
    if (fs) begin
      col_pos = 0;
      in_first_row = 1'b1;
    end
    at_last = (col_pos + 1 >= w);
    above = row_above[col_pos];
    if (!in_first_row && col_pos > 0) begin
      a = prev_above;
      b = above;
      c = prev_px;
      d = px;
      dxh = d + c - b - a;
      dyh = d + b - c - a;
      s = dxh * dxh + dyh * dyh;
      big = 64 * s;
      r = int_sqrt(big);
      if (big - r * r > r) r++;
      lvl = int_sqrt(s / 4);
      if (lvl > 255) lvl = 255;
      if (dxh == 0) ang = (dyh < 0) ? 0 : int'(pi_q12_val);
      else ang = cordic_atan2(dxh, -dyh);
      g.dx_half = dxh[9:0];
      g.dy_half = dyh[9:0];
      g.magnitude_q4 = r[12:0];
      g.magnitude_level = lvl[7:0];
      g.angle_q12 = ang[14:0];
      g.row_end = 1'b0;
      expected_grads.push_back(g);
    end
    if (!in_first_row && at_last) begin
      g = '0;
      g.row_end = 1'b1;
      expected_grads.push_back(g);
    end
    prev_above = above;
    prev_px = px;
    row_above[col_pos] = px;
    if (at_last) begin
      col_pos = 0;
      in_first_row = 1'b0;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Pixel driver: takes beats from the pending queue and offers them with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        track_pixel(pixel, frame_start);
        pixels_sent++;
      end
      // A beat that was refused stays on the port unchanged.
      if (!(push && full)) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          pixel <= pending_pixels[0].px;
          frame_start <= pending_pixels[0].fs;
          void'(pending_pixels.pop_front());
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each popped beat and drives pop, including one long hold-off
  // so that the result queue backs up into the pixel input.
  int unsigned hold_cycles = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    pgma_pkg::res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_grads.size() == 0) begin
          $error("result beat with nothing expected");
          error_count++;
        end else begin
          want = expected_grads.pop_front();
          if (dx_half !== want.dx_half) begin
            $error("dx_half: expected %0d, got %0d", want.dx_half, dx_half);
            error_count++;
          end
          if (dy_half !== want.dy_half) begin
            $error("dy_half: expected %0d, got %0d", want.dy_half, dy_half);
            error_count++;
          end
          if (magnitude_q4 !== want.magnitude_q4) begin
            $error("magnitude_q4: expected %0d, got %0d", want.magnitude_q4, magnitude_q4);
            error_count++;
          end
          if (magnitude_level !== want.magnitude_level) begin
            $error("magnitude_level: expected %0d, got %0d",
                   want.magnitude_level, magnitude_level);
            error_count++;
          end
          if (angle_q12 !== want.angle_q12) begin
            $error("angle_q12: expected %0d, got %0d", want.angle_q12, angle_q12);
            error_count++;
          end
          if (row_end !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, row_end);
            error_count++;
          end
          if (want.row_end) tail_beats++;
          else grads_checked++;
        end
      end
      if (!hold_done && grads_checked == 150) begin
        hold_done = 1'b1;
        hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= receiver_gap_pct);
      end
    end
  end

  task automatic queue_pixel(logic [7:0] px, logic fs);
    pix_beat_t b;
    b.px = px;
    b.fs = fs;
    pending_pixels.push_back(b);
  endtask

  // A frame with random content; a small share of beats restarts the frame mid-row
  // or uses saturated samples.
  task automatic queue_random_frame(int unsigned count);
    int unsigned pick;
    logic [7:0] px;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) px = 8'd0;
      else if (pick == 1) px = 8'd255;
      else px = $urandom_range(255);
      queue_pixel(px, (i == 0) || ($urandom_range(199) == 0));
    end
  endtask

  // Wait until every pixel went in and every result came out, then let the back end settle.
  task automatic drain;
    while (pending_pixels.size() > 0 || push || expected_grads.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic set_width(logic [12:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = value;
  endtask

  initial begin
    col_pos = 0;
    in_first_row = 1'b1;
    prev_px = '0;
    prev_above = '0;
    width_reg = 13'd640;
    foreach (row_above[i]) row_above[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The width after reset is 640: one full row plus part of the next.
    queue_random_frame(700);
    drain();

    // Two-pixel rows that hit the field extremes: full positive and negative dx,
    // diagonal gradients, a flat window (angle pi), and dx zero with dy negative.
    set_width(13'd2);
    queue_pixel(8'd0, 1'b1);   queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd0, 1'b0);   queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd255, 1'b0); queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0, 1'b0);   queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd128, 1'b0); queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd128, 1'b0); queue_pixel(8'd0, 1'b0);
    // Frame restart in the middle of a row.
    queue_pixel(8'd77, 1'b0);  queue_pixel(8'd200, 1'b1);
    queue_pixel(8'd13, 1'b0);  queue_pixel(8'd90, 1'b0);
    queue_pixel(8'd255, 1'b0);
    drain();

    // Widths below the minimum are clamped to two.
    set_width(13'd0);
    queue_random_frame(150);
    drain();
    set_width(13'd1);
    queue_random_frame(100);
    drain();

    sender_gap_pct = 65;
    receiver_gap_pct = 22;
    set_width(13'd5);
    queue_random_frame(300);
    drain();
    set_width(13'd33);
    queue_random_frame(300);
    drain();

    sender_gap_pct = 0;
    receiver_gap_pct = 0;
    set_width(13'd17);
    queue_random_frame(200);
    drain();
    set_width(13'd3);
    queue_random_frame(150);
    drain();

    $display("Sent %0d pixels over widths 2 to 640; checked %0d gradient beats and %0d row ends.",
             pixels_sent, grads_checked, tail_beats);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
